FILE: sv/fpd_pkg.sv
// Shared types and constants for the finger presence detector.
`timescale 1ns / 1ps

package fpd_pkg;

    // Field widths
    localparam int SAMPLE_W   = 18;
    localparam int THR_W      = 19;
    localparam int RUN_W      = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 18;

    // Window default
    localparam int WINDOW_DEPTH_DEF = 32;

    // Decision constants
    localparam int SPAN_DIV      = 2000;
    localparam int CLOSE_FLOOR   = 80;
    localparam int STEP_DIV      = 10;
    localparam int EMA_SHIFT     = 5;     // EMA weight 31/32
    localparam int RUN_MAX       = 255;
    localparam int STRONG_SPAN   = 2;

    // Reciprocals for the constant divides, exact for 18-bit operands
    localparam int SPAN_RECIP    = 134218;  // ceil(2^28 / SPAN_DIV)
    localparam int SPAN_SHIFT    = 28;
    localparam int STEP_RECIP    = 419431;  // ceil(2^22 / STEP_DIV)
    localparam int STEP_SHIFT    = 22;

    // Register reset values
    localparam int DC_MIN_RST        = 100;
    localparam int SATURATION_RST    = 260000;
    localparam int STRONG_RST        = 3000;
    localparam int SPAN_MIN_RST      = 4;
    localparam int STEP_MIN_RST      = 50;
    localparam int FOUND_CONFIRM_RST = 2;
    localparam int LOST_CONFIRM_RST  = 20;
    localparam int MIN_READY_RST     = 8;

    // Register indexes on the configuration port
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DC_MIN        = 3'd0,
        CFG_SATURATION    = 3'd1,
        CFG_STRONG        = 3'd2,
        CFG_SPAN_MIN      = 3'd3,
        CFG_STEP_MIN      = 3'd4,
        CFG_FOUND_CONFIRM = 3'd5,
        CFG_LOST_CONFIRM  = 3'd6,
        CFG_MIN_READY     = 3'd7
    } t_cfg_idx;

    // Sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_DIV_IR,
        S_DIV_RED,
        S_SPAN_REQ,
        S_STEP_REQ,
        S_DECIDE,
        S_OUT
    } t_state;

    // Input transaction payload
    typedef struct packed {
        logic [SAMPLE_W-1:0] ir_sample;
        logic [SAMPLE_W-1:0] red_sample;
    } t_in;

    // Output transaction payload
    typedef struct packed {
        logic                contact;
        logic [SAMPLE_W-1:0] mean_ir;
        logic [SAMPLE_W-1:0] avg_red;
        logic [SAMPLE_W-1:0] span_ir;
        logic [THR_W-1:0]    ir_thresh;
    } t_out;

endpackage

FILE: sv/fpd_ram.sv
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps

module fpd_ram #(
    parameter int WIDTH = 18,
    parameter int DEPTH = 32,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: sv/fpd_div.sv
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps

module fpd_div #(
    parameter int DW = 23,
    parameter int VW = 11,
    localparam int CW = $clog2(DW + 1)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [DW-1:0] i_dividend,
    input  logic [VW-1:0] i_divisor,
    output logic          o_done,
    output logic [DW-1:0] o_quotient
);

    logic          r_busy, n_busy;
    logic          r_done, n_done;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [VW-1:0] r_rem, n_rem;
    logic [DW-1:0] r_quo, n_quo;
    logic [VW-1:0] r_dvs, n_dvs;

    logic [VW:0]   rem_sh;
    logic [VW:0]   rem_sub;
    logic          fits;

    // Shift in the next dividend bit and trial-subtract
    assign rem_sh  = {r_rem, r_quo[DW-1]};
    assign rem_sub = rem_sh - {1'b0, r_dvs};
    assign fits    = (rem_sh >= {1'b0, r_dvs});

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_dvs  = r_dvs;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = CW'(DW);
            n_rem  = '0;
            n_quo  = i_dividend;
            n_dvs  = i_divisor;
        end else if (r_busy) begin
            n_rem = fits ? rem_sub[VW-1:0] : rem_sh[VW-1:0];
            n_quo = {r_quo[DW-2:0], fits};
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == CW'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_dvs <= n_dvs;
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

FILE: sv/finger_presence_detector.sv
// Top level of the finger presence detector: window memory, sequencer and decision logic.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready / i_in_data) carries one IR and one
//   red sample per transaction. Output channel (o_out_valid / i_out_ready /
//   o_out_data) returns one result per input: presence flag, floor means of
//   both channels, IR span and the current IR threshold.
//   Samples go into two window RAMs; each item walks the filled part of the
//   window (one entry per cycle), then divides both sums by the fill count on
//   one bit-serial divider. mean/2000 and baseline/10 are reciprocal multiplies.
//   The sequencer scans, drains, divides IR then red (SW-bit quotients, SW =
//   18 + log2(depth)), forms span and step requirements, decides and outputs;
//   with fewer than min_ready samples held it skips requirements and decide.
//   One item is in work at a time: the next input is taken in the cycle after
//   the result is registered; the window walk and the divider set the rate.
//   The next input transaction is taken while a finished result still waits in
//   the output register; if the receiver stalls, the following result holds
//   in the sequencer until the output register frees up.
//   Reset empties the window, clears presence and baseline, and loads the
//   config registers with defaults. Config writes (i_cfg_we) take effect at once;
//   the user must make them while the block is idle, which it does not enforce.
`timescale 1ns / 1ps

module finger_presence_detector #(
    parameter int WINDOW_DEPTH = fpd_pkg::WINDOW_DEPTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // Sample input
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  fpd_pkg::t_in                   i_in_data,
    // Result output
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output fpd_pkg::t_out                  o_out_data,
    // Configuration writes
    input  logic                           i_cfg_we,
    input  logic [fpd_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [fpd_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    localparam int SWD = fpd_pkg::SAMPLE_W;
    localparam int RW  = fpd_pkg::RUN_W;
    localparam int TW  = fpd_pkg::THR_W;
    localparam int AW  = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int FW  = $clog2(WINDOW_DEPTH + 1);
    localparam int SW  = SWD + AW;
    localparam int DVW = FW;
    localparam int CW  = (FW > RW) ? FW + 1 : RW + 1;
    localparam int EW  = SWD + fpd_pkg::EMA_SHIFT + 1;
    localparam int PW  = fpd_pkg::SPAN_SHIFT + SWD;

    // Configuration registers
    logic [SWD-1:0] r_dc_min, r_saturation, r_strong, r_span_min, r_step_min;
    logic [RW-1:0]  r_found_confirm, r_lost_confirm, r_min_ready;

    // Sequencer and window bookkeeping
    fpd_pkg::t_state r_state, n_state;
    logic [AW-1:0]   r_wptr, n_wptr;
    logic [FW-1:0]   r_fill, n_fill;
    logic [FW-1:0]   r_scan_idx, n_scan_idx;
    logic            r_acc_en, n_acc_en;
    logic            r_div_run, n_div_run;

    // Statistics accumulators and quotients
    logic [SW-1:0]   r_isum, n_isum, r_rsum, n_rsum;
    logic [SWD-1:0]  r_imin, n_imin, r_imax, n_imax;
    logic [SWD-1:0]  r_mean_ir, n_mean_ir, r_mean_red, n_mean_red;
    logic [SWD-1:0]  r_q_span, n_q_span, r_q_base, n_q_base;

    // Detector state
    logic [RW-1:0]   r_found_run, n_found_run, r_lost_run, n_lost_run;
    logic            r_present, n_present;
    logic            r_base_known, n_base_known;
    logic [SWD-1:0]  r_base, n_base;
    logic [TW-1:0]   r_thr, n_thr;

    // Output register
    fpd_pkg::t_out   r_out, n_out;
    logic            r_out_valid, n_out_valid;

    // Memory and divider hookups
    logic            in_acc;
    logic [SWD-1:0]  ir_rd, red_rd;
    logic            div_start, div_done;
    logic [SW-1:0]   div_dividend, div_quot;
    logic [DVW-1:0]  div_divisor;

    // Reciprocal products for the constant divides
    logic [PW-1:0]   span_prod, step_prod;
    logic [SWD-1:0]  span_q, step_q;

    // Decision terms
    logic [SWD-1:0]  span;
    logic [SWD-1:0]  span_req, step_req, close_lim, base_diff;
    logic            dc_ok, pulse, stepc, strong_cand, cand;
    logic            dim_ir, near_base, is_ready;
    logic [RW-1:0]   found_inc, lost_inc;
    logic [EW-1:0]   ema_sum;

    assign in_acc     = i_in_valid && o_in_ready;
    assign o_in_ready = (r_state == fpd_pkg::S_IDLE);

    // Window memories
    fpd_ram #(.WIDTH(SWD), .DEPTH(WINDOW_DEPTH)) u_ir_ram (
        .i_clk   (i_clk),
        .i_we    (in_acc),
        .i_waddr (r_wptr),
        .i_wdata (i_in_data.ir_sample),
        .i_raddr (r_scan_idx[AW-1:0]),
        .o_rdata (ir_rd)
    );

    fpd_ram #(.WIDTH(SWD), .DEPTH(WINDOW_DEPTH)) u_red_ram (
        .i_clk   (i_clk),
        .i_we    (in_acc),
        .i_waddr (r_wptr),
        .i_wdata (i_in_data.red_sample),
        .i_raddr (r_scan_idx[AW-1:0]),
        .o_rdata (red_rd)
    );

    // Divider for the window means
    fpd_div #(.DW(SW), .VW(DVW)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quotient (div_quot)
    );

    // Divider operand select
    always_comb begin
        div_dividend = r_isum;
        div_divisor  = DVW'(r_fill);
        unique case (r_state)
            fpd_pkg::S_DIV_RED: begin
                div_dividend = r_rsum;
                div_divisor  = DVW'(r_fill);
            end
            default: begin
                div_dividend = r_isum;
                div_divisor  = DVW'(r_fill);
            end
        endcase
    end

    // mean/2000 and baseline/10 as constant multiplies, one register stage each
    assign span_prod = PW'(r_mean_ir) * PW'(fpd_pkg::SPAN_RECIP);
    assign step_prod = PW'(r_base) * PW'(fpd_pkg::STEP_RECIP);
    assign span_q    = span_prod[fpd_pkg::SPAN_SHIFT +: SWD];
    assign step_q    = step_prod[fpd_pkg::STEP_SHIFT +: SWD];

    // Decision terms from the statistics of this item
    assign span      = r_imax - r_imin;
    assign is_ready  = (CW'(r_fill) >= CW'(r_min_ready));
    assign span_req  = (r_span_min > r_q_span) ? r_span_min : r_q_span;
    assign step_req  = (r_step_min > r_q_base) ? r_step_min : r_q_base;
    assign close_lim = (SWD'(fpd_pkg::CLOSE_FLOOR) > r_q_base) ?
                       SWD'(fpd_pkg::CLOSE_FLOOR) : r_q_base;
    assign base_diff = (r_mean_ir >= r_base) ? (r_mean_ir - r_base) : (r_base - r_mean_ir);
    assign dc_ok     = (r_mean_ir >= r_dc_min) && (r_mean_ir < r_saturation);
    assign pulse     = dc_ok && (span >= span_req);
    assign stepc     = r_base_known && dc_ok && (base_diff >= step_req);
    assign strong_cand = dc_ok && (r_mean_ir >= r_strong) &&
                         (span >= SWD'(fpd_pkg::STRONG_SPAN));
    assign cand      = pulse || stepc || strong_cand;
    assign dim_ir    = (r_mean_ir < (r_dc_min >> 1));
    assign near_base = r_base_known && (base_diff <= close_lim) && (span < span_req);
    assign found_inc = (r_found_run != RW'(fpd_pkg::RUN_MAX)) ?
                       (r_found_run + 1'b1) : r_found_run;
    assign lost_inc  = (r_lost_run != RW'(fpd_pkg::RUN_MAX)) ?
                       (r_lost_run + 1'b1) : r_lost_run;
    // 31/32 floor EMA: (32*base - base + mean) >> 5
    assign ema_sum   = (EW'(r_base) << fpd_pkg::EMA_SHIFT) - EW'(r_base) + EW'(r_mean_ir);

    // Sequencer: next state and datapath updates
    always_comb begin
        n_state      = r_state;
        n_wptr       = r_wptr;
        n_fill       = r_fill;
        n_scan_idx   = r_scan_idx;
        n_acc_en     = 1'b0;
        n_div_run    = r_div_run;
        n_isum       = r_isum;
        n_rsum       = r_rsum;
        n_imin       = r_imin;
        n_imax       = r_imax;
        n_mean_ir    = r_mean_ir;
        n_mean_red   = r_mean_red;
        n_q_span     = r_q_span;
        n_q_base     = r_q_base;
        n_found_run  = r_found_run;
        n_lost_run   = r_lost_run;
        n_present    = r_present;
        n_base_known = r_base_known;
        n_base       = r_base;
        n_thr        = r_thr;
        n_out        = r_out;
        n_out_valid  = r_out_valid && !i_out_ready;
        div_start    = 1'b0;

        // Accumulate a window entry read in the previous cycle
        if (r_acc_en) begin
            n_isum = r_isum + SW'(ir_rd);
            n_rsum = r_rsum + SW'(red_rd);
            if (ir_rd < r_imin) n_imin = ir_rd;
            if (ir_rd > r_imax) n_imax = ir_rd;
        end

        unique case (r_state)
            fpd_pkg::S_IDLE: begin
                if (in_acc) begin
                    n_wptr     = (r_wptr == AW'(WINDOW_DEPTH - 1)) ? '0 : r_wptr + 1'b1;
                    n_fill     = (r_fill != FW'(WINDOW_DEPTH)) ? r_fill + 1'b1 : r_fill;
                    n_scan_idx = '0;
                    n_isum     = '0;
                    n_rsum     = '0;
                    n_imin     = '1;
                    n_imax     = '0;
                    n_state    = fpd_pkg::S_SCAN;
                end
            end
            fpd_pkg::S_SCAN: begin
                n_acc_en   = 1'b1;
                n_scan_idx = r_scan_idx + 1'b1;
                if (FW'(r_scan_idx + 1'b1) == r_fill) begin
                    n_state = fpd_pkg::S_DRAIN;
                end
            end
            fpd_pkg::S_DRAIN: begin
                n_state = fpd_pkg::S_DIV_IR;
            end
            fpd_pkg::S_DIV_IR,
            fpd_pkg::S_DIV_RED: begin
                if (!r_div_run) begin
                    div_start = 1'b1;
                    n_div_run = 1'b1;
                end else if (div_done) begin
                    n_div_run = 1'b0;
                    unique case (r_state)
                        fpd_pkg::S_DIV_IR: begin
                            n_mean_ir = div_quot[SWD-1:0];
                            n_state   = fpd_pkg::S_DIV_RED;
                        end
                        default: begin
                            n_mean_red = div_quot[SWD-1:0];
                            n_state    = is_ready ? fpd_pkg::S_SPAN_REQ : fpd_pkg::S_OUT;
                        end
                    endcase
                end
            end
            fpd_pkg::S_SPAN_REQ: begin
                n_q_span = span_q;
                n_state  = fpd_pkg::S_STEP_REQ;
            end
            fpd_pkg::S_STEP_REQ: begin
                n_q_base = step_q;
                n_state  = fpd_pkg::S_DECIDE;
            end
            fpd_pkg::S_DECIDE: begin
                // Threshold from the baseline held before this item
                if (r_base_known) begin
                    n_thr = TW'(r_base) + TW'(step_req);
                end else begin
                    n_thr = TW'(r_dc_min);
                end
                if (!r_present) begin
                    if (cand) begin
                        n_found_run = found_inc;
                        if (found_inc >= r_found_confirm) begin
                            n_present  = 1'b1;
                            n_lost_run = '0;
                        end
                    end else begin
                        n_found_run  = '0;
                        n_base_known = 1'b1;
                        n_base       = r_base_known ?
                                       ema_sum[fpd_pkg::EMA_SHIFT +: SWD] : r_mean_ir;
                    end
                end else begin
                    if (dim_ir || near_base) begin
                        n_lost_run = lost_inc;
                        if (lost_inc >= r_lost_confirm) begin
                            n_present   = 1'b0;
                            n_found_run = '0;
                        end
                    end else begin
                        n_lost_run = '0;
                    end
                end
                n_state = fpd_pkg::S_OUT;
            end
            fpd_pkg::S_OUT: begin
                // Wait for the output register to free up
                if (!r_out_valid || i_out_ready) begin
                    n_out.contact   = r_present;
                    n_out.mean_ir   = r_mean_ir;
                    n_out.avg_red   = r_mean_red;
                    n_out.span_ir   = span;
                    n_out.ir_thresh = r_thr;
                    n_out_valid     = 1'b1;
                    n_state         = fpd_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = fpd_pkg::S_IDLE;
            end
        endcase
    end

    // Configuration write decode
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dc_min        <= SWD'(fpd_pkg::DC_MIN_RST);
            r_saturation    <= SWD'(fpd_pkg::SATURATION_RST);
            r_strong        <= SWD'(fpd_pkg::STRONG_RST);
            r_span_min      <= SWD'(fpd_pkg::SPAN_MIN_RST);
            r_step_min      <= SWD'(fpd_pkg::STEP_MIN_RST);
            r_found_confirm <= RW'(fpd_pkg::FOUND_CONFIRM_RST);
            r_lost_confirm  <= RW'(fpd_pkg::LOST_CONFIRM_RST);
            r_min_ready     <= RW'(fpd_pkg::MIN_READY_RST);
        end else if (i_cfg_we) begin
            unique case (fpd_pkg::t_cfg_idx'(i_cfg_idx))
                fpd_pkg::CFG_DC_MIN:        r_dc_min        <= i_cfg_data[SWD-1:0];
                fpd_pkg::CFG_SATURATION:    r_saturation    <= i_cfg_data[SWD-1:0];
                fpd_pkg::CFG_STRONG:        r_strong        <= i_cfg_data[SWD-1:0];
                fpd_pkg::CFG_SPAN_MIN:      r_span_min      <= i_cfg_data[SWD-1:0];
                fpd_pkg::CFG_STEP_MIN:      r_step_min      <= i_cfg_data[SWD-1:0];
                fpd_pkg::CFG_FOUND_CONFIRM: r_found_confirm <= i_cfg_data[RW-1:0];
                fpd_pkg::CFG_LOST_CONFIRM:  r_lost_confirm  <= i_cfg_data[RW-1:0];
                fpd_pkg::CFG_MIN_READY:     r_min_ready     <= i_cfg_data[RW-1:0];
                default: ;
            endcase
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= fpd_pkg::S_IDLE;
            r_wptr       <= '0;
            r_fill       <= '0;
            r_scan_idx   <= '0;
            r_acc_en     <= 1'b0;
            r_div_run    <= 1'b0;
            r_found_run  <= '0;
            r_lost_run   <= '0;
            r_present    <= 1'b0;
            r_base_known <= 1'b0;
            r_base       <= '0;
            r_thr        <= TW'(fpd_pkg::DC_MIN_RST);
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_wptr       <= n_wptr;
            r_fill       <= n_fill;
            r_scan_idx   <= n_scan_idx;
            r_acc_en     <= n_acc_en;
            r_div_run    <= n_div_run;
            r_found_run  <= n_found_run;
            r_lost_run   <= n_lost_run;
            r_present    <= n_present;
            r_base_known <= n_base_known;
            r_base       <= n_base;
            r_thr        <= n_thr;
            r_out_valid  <= n_out_valid;
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_isum     <= n_isum;
        r_rsum     <= n_rsum;
        r_imin     <= n_imin;
        r_imax     <= n_imax;
        r_mean_ir  <= n_mean_ir;
        r_mean_red <= n_mean_red;
        r_q_span   <= n_q_span;
        r_q_base   <= n_q_base;
        r_out      <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

FILE: test/finger_presence_detector_test.sv
// Self-checking testbench for the finger presence detector: random scenes checked against a predictor.
`timescale 1ns / 1ps

module finger_presence_detector_test;

    localparam int          WIN         = fpd_pkg::WINDOW_DEPTH_DEF;
    localparam int unsigned SAMPLE_MAX  = (1 << fpd_pkg::SAMPLE_W) - 1;
    localparam int unsigned SETTLE      = 200;        // beyond one full-window item
    localparam int unsigned LONG_HOLD   = 1200;       // receiver hold-off, in cycles
    localparam int unsigned CYCLE_LIMIT = 3_000_000;

    typedef enum int {
        SCENE_AIR,
        SCENE_FINGER,
        SCENE_ZERO,
        SCENE_STEP,
        SCENE_NOISE,
        SCENE_SAT
    } t_scene;

    // Presence predictor plus the queue of results it expects
    class presence_model;
        int unsigned   ir_win[WIN];
        int unsigned   red_win[WIN];
        int unsigned   wr_ptr, filled, found_run, lost_run, base_level, thr_level;
        bit            present, base_known;
        int unsigned   cfg[8];
        fpd_pkg::t_out pending[$];
        int unsigned   errors;

        function new();
            wr_ptr     = 0;
            filled     = 0;
            found_run  = 0;
            lost_run   = 0;
            present    = 1'b0;
            base_known = 1'b0;
            base_level = 0;
            errors     = 0;
            cfg[fpd_pkg::CFG_DC_MIN]        = fpd_pkg::DC_MIN_RST;
            cfg[fpd_pkg::CFG_SATURATION]    = fpd_pkg::SATURATION_RST;
            cfg[fpd_pkg::CFG_STRONG]        = fpd_pkg::STRONG_RST;
            cfg[fpd_pkg::CFG_SPAN_MIN]      = fpd_pkg::SPAN_MIN_RST;
            cfg[fpd_pkg::CFG_STEP_MIN]      = fpd_pkg::STEP_MIN_RST;
            cfg[fpd_pkg::CFG_FOUND_CONFIRM] = fpd_pkg::FOUND_CONFIRM_RST;
            cfg[fpd_pkg::CFG_LOST_CONFIRM]  = fpd_pkg::LOST_CONFIRM_RST;
            cfg[fpd_pkg::CFG_MIN_READY]     = fpd_pkg::MIN_READY_RST;
            thr_level  = fpd_pkg::DC_MIN_RST;
        endfunction

        function int unsigned max2(int unsigned a, int unsigned b);
            return (a > b) ? a : b;
        endfunction

        function int unsigned absdiff(int unsigned a, int unsigned b);
            return (a >= b) ? a - b : b - a;
        endfunction

        function void set_reg(fpd_pkg::t_cfg_idx idx, int unsigned value);
            case (idx) inside
                fpd_pkg::CFG_FOUND_CONFIRM, fpd_pkg::CFG_LOST_CONFIRM,
                fpd_pkg::CFG_MIN_READY: begin
                    cfg[idx] = value & ((1 << fpd_pkg::RUN_W) - 1);
                end
                default: begin
                    cfg[idx] = value & SAMPLE_MAX;
                end
            endcase
        endfunction

        // Store one sample pair, update the decision state, queue the result
        function void take_sample(fpd_pkg::t_in item);
            longint unsigned ir_sum, red_sum;
            int unsigned     lo, hi, m_ir, m_red, span, span_req, step_req, lim;
            bit              dc_ok, cand, quiet;
            fpd_pkg::t_out   r;
            ir_win[wr_ptr]  = item.ir_sample;
            red_win[wr_ptr] = item.red_sample;
            wr_ptr = (wr_ptr + 1) % WIN;
            if (filled < WIN) filled++;

            // statistics over the written entries
            ir_sum  = 0;
            red_sum = 0;
            lo      = SAMPLE_MAX;
            hi      = 0;
            for (int i = 0; i < filled; i++) begin
                ir_sum  += ir_win[i];
                red_sum += red_win[i];
                if (ir_win[i] < lo) lo = ir_win[i];
                if (ir_win[i] > hi) hi = ir_win[i];
            end
            m_ir  = ir_sum / filled;
            m_red = red_sum / filled;
            span  = hi - lo;

            // decisions only once enough samples are held
            if (filled >= cfg[fpd_pkg::CFG_MIN_READY]) begin
                span_req = max2(cfg[fpd_pkg::CFG_SPAN_MIN], m_ir / fpd_pkg::SPAN_DIV);
                dc_ok = (m_ir >= cfg[fpd_pkg::CFG_DC_MIN]) &&
                        (m_ir < cfg[fpd_pkg::CFG_SATURATION]);
                cand  = dc_ok && ((span >= span_req) ||
                        (m_ir >= cfg[fpd_pkg::CFG_STRONG] && span >= fpd_pkg::STRONG_SPAN));
                if (base_known) begin
                    step_req  = max2(cfg[fpd_pkg::CFG_STEP_MIN], base_level / fpd_pkg::STEP_DIV);
                    thr_level = (base_level + step_req) & ((1 << fpd_pkg::THR_W) - 1);
                    if (dc_ok && absdiff(m_ir, base_level) >= step_req) cand = 1'b1;
                end else begin
                    thr_level = cfg[fpd_pkg::CFG_DC_MIN];
                end

                if (!present) begin
                    if (cand) begin
                        if (found_run < fpd_pkg::RUN_MAX) found_run++;
                        if (found_run >= cfg[fpd_pkg::CFG_FOUND_CONFIRM]) begin
                            present  = 1'b1;
                            lost_run = 0;
                        end
                    end else begin
                        // open-air reading teaches the baseline
                        found_run  = 0;
                        base_level = base_known ?
                                     (base_level * 31 + m_ir) >> fpd_pkg::EMA_SHIFT : m_ir;
                        base_known = 1'b1;
                    end
                end else begin
                    quiet = m_ir < cfg[fpd_pkg::CFG_DC_MIN] / 2;
                    if (base_known) begin
                        lim = max2(fpd_pkg::CLOSE_FLOOR, base_level / fpd_pkg::STEP_DIV);
                        if (absdiff(m_ir, base_level) <= lim && span < span_req) quiet = 1'b1;
                    end
                    if (quiet) begin
                        if (lost_run < fpd_pkg::RUN_MAX) lost_run++;
                        if (lost_run >= cfg[fpd_pkg::CFG_LOST_CONFIRM]) begin
                            present   = 1'b0;
                            found_run = 0;
                        end
                    end else begin
                        lost_run = 0;
                    end
                end
            end

            r.contact   = present;
            r.mean_ir   = fpd_pkg::SAMPLE_W'(m_ir);
            r.avg_red   = fpd_pkg::SAMPLE_W'(m_red);
            r.span_ir   = fpd_pkg::SAMPLE_W'(span);
            r.ir_thresh = fpd_pkg::THR_W'(thr_level);
            pending.push_back(r);
        endfunction

        function void check_field(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_result(fpd_pkg::t_out got);
            fpd_pkg::t_out want;
            if (pending.size() == 0) begin
                $display("%0t: result with none expected, actual %h", $time, got);
                errors++;
                return;
            end
            want = pending.pop_front();
            check_field("contact", want.contact, got.contact);
            check_field("mean_ir", want.mean_ir, got.mean_ir);
            check_field("avg_red", want.avg_red, got.avg_red);
            check_field("span_ir", want.span_ir, got.span_ir);
            check_field("ir_thresh", want.ir_thresh, got.ir_thresh);
        endfunction
    endclass

    logic                           i_clk      = 1'b0;
    logic                           i_rst_n    = 1'b0;
    logic                           i_in_valid = 1'b0;
    logic                           o_in_ready;
    fpd_pkg::t_in                   i_in_data  = '0;
    logic                           o_out_valid;
    logic                           i_out_ready = 1'b0;
    fpd_pkg::t_out                  o_out_data;
    logic                           i_cfg_we   = 1'b0;
    logic [fpd_pkg::CFG_IDX_W-1:0]  i_cfg_idx  = '0;
    logic [fpd_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;

    presence_model model;
    int unsigned   next_gap  = 0;
    int unsigned   air_level = 0;
    int unsigned   cycles    = 0;
    bit            idle_on   = 1'b1;
    bit            hold_req  = 1'b0;

    finger_presence_detector i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    // Clock
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Run limit
    initial begin
        while (cycles < CYCLE_LIMIT) @(posedge i_clk) cycles++;
        $display("Simulation FAILED");
        $finish;
    end

    // Idle gap before the next input transaction: mostly short, a few long
    function automatic int unsigned pick_gap();
        int unsigned r;
        if (!idle_on) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 15);
        return $urandom_range(20, 80);
    endfunction

    function automatic fpd_pkg::t_in pack_item(int unsigned ir, int unsigned red);
        fpd_pkg::t_in item;
        item.ir_sample  = fpd_pkg::SAMPLE_W'(ir);
        item.red_sample = fpd_pkg::SAMPLE_W'(red);
        return item;
    endfunction

    // Offer one item and hold it until the transaction; valid stays up for a gapless next item
    task automatic send_item(fpd_pkg::t_in item);
        repeat (next_gap) @(posedge i_clk);
        if (!i_in_valid) i_in_valid <= 1'b1;
        i_in_data <= item;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        model.take_sample(item);
        next_gap = pick_gap();
        if (next_gap != 0) i_in_valid <= 1'b0;
    endtask

    task automatic stop_sending();
        if (next_gap == 0) i_in_valid <= 1'b0;
    endtask

    task automatic wait_idle();
        while (model.pending.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(fpd_pkg::t_cfg_idx idx, int unsigned value);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= fpd_pkg::CFG_DATA_W'(value);
        @(posedge i_clk);
        model.set_reg(idx, value);
    endtask

    task automatic set_all(int unsigned dc, int unsigned sat, int unsigned strong_lvl,
                           int unsigned span, int unsigned step, int unsigned found,
                           int unsigned lost, int unsigned ready);
        write_reg(fpd_pkg::CFG_DC_MIN, dc);
        write_reg(fpd_pkg::CFG_SATURATION, sat);
        write_reg(fpd_pkg::CFG_STRONG, strong_lvl);
        write_reg(fpd_pkg::CFG_SPAN_MIN, span);
        write_reg(fpd_pkg::CFG_STEP_MIN, step);
        write_reg(fpd_pkg::CFG_FOUND_CONFIRM, found);
        write_reg(fpd_pkg::CFG_LOST_CONFIRM, lost);
        write_reg(fpd_pkg::CFG_MIN_READY, ready);
        i_cfg_we <= 1'b0;
    endtask

    // Random scenes: open air, finger with pulse, near zero, baseline step, noise, saturation
    task automatic play_scenes(int unsigned count, int unsigned min_len, int unsigned max_len);
        int unsigned done, len, r, level, amp, period, half, ph, ramp, noise, v, red;
        t_scene      kind;
        done = 0;
        while (done < count) begin
            r      = $urandom_range(0, 99);
            len    = $urandom_range(min_len, max_len);
            period = $urandom_range(4, 40);
            half   = period / 2;
            amp    = 0;
            noise  = 0;
            level  = 0;
            if (r < 30) begin
                kind      = SCENE_AIR;
                level     = $urandom_range(0, 3000);
                noise     = $urandom_range(0, 1);
                air_level = level;
            end else if (r < 65) begin
                kind  = SCENE_FINGER;
                level = $urandom_range(2000, 200000);
                amp   = $urandom_range(0, level / 8 + 10);
                noise = $urandom_range(0, 5);
            end else if (r < 75) begin
                kind  = SCENE_ZERO;
                noise = $urandom_range(0, 3);
            end else if (r < 85) begin
                kind  = SCENE_STEP;
                level = air_level + $urandom_range(20, 3000);
            end else if (r < 93) begin
                kind  = SCENE_NOISE;
                len   = $urandom_range(1, 20);
            end else begin
                kind  = SCENE_SAT;
                level = $urandom_range(255000, SAMPLE_MAX);
                noise = $urandom_range(0, 50);
            end

            for (int k = 0; k < len && done < count; k++) begin
                ph   = k % period;
                ramp = (ph < half) ? ph : period - ph;
                v    = level + amp * ramp / half + $urandom_range(0, noise);
                if (v > SAMPLE_MAX) v = SAMPLE_MAX;
                red  = v / 2 + $urandom_range(0, 255);
                if (kind == SCENE_NOISE) begin
                    v   = $urandom_range(0, SAMPLE_MAX);
                    red = $urandom_range(0, SAMPLE_MAX);
                end else if (kind == SCENE_ZERO) begin
                    red = $urandom_range(0, 3);
                end
                send_item(pack_item(v, red));
                done++;
            end
        end
    endtask

    // Result side: check each transaction, stall at random while idling is on, hold off long on request
    initial begin : result_side
        int unsigned run_left, hold_left;
        bit          level;
        run_left  = 0;
        hold_left = 0;
        level     = 1'b1;
        forever begin
            @(posedge i_clk);
            if (o_out_valid && i_out_ready) model.check_result(o_out_data);
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = LONG_HOLD;
            end
            if (hold_left != 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else if (!idle_on) begin
                i_out_ready <= 1'b1;
            end else begin
                if (run_left == 0) begin
                    case ($urandom_range(0, 99)) inside
                        [0:59]:  begin level = 1'b1; run_left = $urandom_range(1, 24);   end
                        [60:92]: begin level = 1'b0; run_left = $urandom_range(1, 4);    end
                        default: begin level = 1'b0; run_left = $urandom_range(20, 150); end
                    endcase
                end
                run_left--;
                i_out_ready <= level;
            end
        end
    end

    // Stimulus
    initial begin : stimulus
        model = new();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: field extremes and bit patterns during warm-up, then a pulse, then removal
        for (int k = 0; k < 3; k++) send_item(pack_item(0, 0));
        send_item(pack_item(SAMPLE_MAX, SAMPLE_MAX));
        send_item(pack_item(SAMPLE_MAX, SAMPLE_MAX));
        send_item(pack_item(18'h2AAAA, 18'h15555));
        send_item(pack_item(18'h15555, 18'h2AAAA));
        send_item(pack_item(0, 0));
        for (int k = 0; k < 10; k++) send_item(pack_item(6000 + (k % 2) * 400, 3000));
        for (int k = 0; k < 6; k++) send_item(pack_item(0, 0));

        // Reset settings, long receiver hold-off so the input stalls
        hold_req = 1'b1;
        play_scenes(250, 30, 120);
        stop_sending();
        wait_idle();

        // Typical settings, no idling on either side
        idle_on = 1'b0;
        set_all(200, 250000, 5000, 8, 100, 3, 10, 16);
        play_scenes(250, 30, 120);
        stop_sending();
        wait_idle();
        idle_on = 1'b1;

        // Low extremes: widest level range, single confirms, decide from the first sample
        set_all(0, SAMPLE_MAX, 0, 0, 0, 1, 1, 1);
        play_scenes(150, 20, 80);
        stop_sending();
        wait_idle();

        // Zero confirm counts act like one
        set_all(fpd_pkg::DC_MIN_RST, fpd_pkg::SATURATION_RST, fpd_pkg::STRONG_RST,
                fpd_pkg::SPAN_MIN_RST, fpd_pkg::STEP_MIN_RST, 0, 0, fpd_pkg::MIN_READY_RST);
        play_scenes(120, 20, 80);
        stop_sending();
        wait_idle();

        // High extremes: nothing in range, ready count above the window depth
        set_all(SAMPLE_MAX, 0, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, fpd_pkg::RUN_MAX,
                fpd_pkg::RUN_MAX, fpd_pkg::RUN_MAX);
        play_scenes(60, 10, 40);
        stop_sending();
        wait_idle();

        // Longest confirm runs so the run counters reach saturation
        set_all(fpd_pkg::DC_MIN_RST, SAMPLE_MAX, fpd_pkg::STRONG_RST, fpd_pkg::SPAN_MIN_RST,
                fpd_pkg::STEP_MIN_RST, fpd_pkg::RUN_MAX, fpd_pkg::RUN_MAX, WIN);
        play_scenes(450, 160, 320);
        stop_sending();
        wait_idle();

        // Random settings
        repeat (2) begin
            set_all($urandom_range(0, 2000), $urandom_range(100000, SAMPLE_MAX),
                    $urandom_range(0, 20000), $urandom_range(0, 50), $urandom_range(0, 500),
                    $urandom_range(0, 8), $urandom_range(0, 40), $urandom_range(1, WIN + 2));
            play_scenes(100, 20, 100);
            stop_sending();
            wait_idle();
        end

        // Back to reset values, with another hold-off
        set_all(fpd_pkg::DC_MIN_RST, fpd_pkg::SATURATION_RST, fpd_pkg::STRONG_RST,
                fpd_pkg::SPAN_MIN_RST, fpd_pkg::STEP_MIN_RST, fpd_pkg::FOUND_CONFIRM_RST,
                fpd_pkg::LOST_CONFIRM_RST, fpd_pkg::MIN_READY_RST);
        hold_req = 1'b1;
        play_scenes(200, 30, 120);
        stop_sending();
        wait_idle();

        if (model.errors == 0 && model.pending.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

FILE: files.f
sv/fpd_pkg.sv
sv/fpd_ram.sv
sv/fpd_div.sv
sv/finger_presence_detector.sv
test/finger_presence_detector_test.sv
